// ----- rtl/scws_pkg.sv -----
// ----------------------------------------------------------------------------
// scws_pkg
// Shared types and codes for the smbus command word sequencer: request and
// command word layouts, status codes, transaction kinds and size constants.
// ----------------------------------------------------------------------------
`default_nettype none

package scws_pkg;

    // field width and default block size
    localparam int unsigned CountWidth = 6;
    localparam int unsigned BlockMaxDefault = 32;

    // transaction kinds
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    // request operations
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_KIND    = 2'd1;
    localparam logic [1:0] ST_LONG    = 2'd2;
    localparam logic [1:0] ST_PAYLOAD = 2'd3;

    // one request item
    typedef struct packed {
        logic        op;
        logic        read_not_write;
        logic [1:0]  kind;
        logic [7:0]  command;
        logic [15:0] data_word;
        logic [7:0]  block_len;
        logic [7:0]  payload_byte;
    } req_t;

    // one command word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_read;
        logic       stop_mark;
        logic       restart_mark;
        logic [1:0] status;
        logic       last;
    } word_t;

endpackage

`default_nettype wire

// ----- rtl/smbus_command_word_sequencer.sv -----
// ----------------------------------------------------------------------------
// smbus_command_word_sequencer
// Expands smbus byte, word and block transaction requests into i2c master
// command words with restart and stop marks.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) takes transaction headers and
//   block write payload bytes. word channel (word_valid/word_stall/word)
//   gives one command word per transfer; word.last marks the final word
//   caused by a request.
//   The first word of a request sits in the output register from the cycle
//   after its transfer. Each further word is loaded in the cycle after
//   the previous one is taken, and a request produces 1 to 1 + BLOCK_MAX
//   words. The next request is accepted in the same cycle the final word
//   of the current one is taken.
//   A single down counter and byte shifter, reloaded per header, walks out
//   the words after the first; it sets the one-word-per-cycle rate while
//   the receiver does not stall. When the receiver stalls, the current word
//   holds and req_stall stays high until the final word is taken.
//   Reset empties the output register, clears the word counter and the
//   count of outstanding block write payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module smbus_command_word_sequencer #(
    parameter int unsigned BLOCK_MAX = scws_pkg::BlockMaxDefault
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_stall,
    input  wire scws_pkg::req_t req,
    output logic                word_valid,
    input  wire logic           word_stall,
    output scws_pkg::word_t     word
);

    localparam int unsigned CW = scws_pkg::CountWidth;

    // registers
    logic                  word_valid_reg, word_valid_next;
    scws_pkg::word_t       word_reg, word_next;
    logic [CW-1:0]         rem_reg, rem_next;
    logic [CW-1:0]         pay_reg, pay_next;
    logic                  rd_mode_reg, rd_mode_next;
    logic                  first_reg, first_next;
    logic [15:0]           dw_reg, dw_next;

    logic                  free;
    logic                  req_take;
    logic                  word_take;
    logic [CW-1:0]         rlen;
    logic                  too_long;

    // handshake
    assign word_take = word_valid_reg && !word_stall;
    assign free      = !word_valid_reg || (word_take && (rem_reg == '0));
    assign req_stall = !free;
    assign req_take  = req_valid && free;

    assign too_long = (req.block_len > 8'(BLOCK_MAX));

    // read request count for a header
    always_comb
    begin
        case (req.kind)
            scws_pkg::KIND_BYTE: rlen = CW'(1);
            scws_pkg::KIND_WORD: rlen = CW'(2);
            default:             rlen = req.block_len[CW-1:0];
        endcase
    end

    // next state
    always_comb
    begin
        word_valid_next = word_valid_reg;
        word_next       = word_reg;
        rem_next        = rem_reg;
        pay_next        = pay_reg;
        rd_mode_next    = rd_mode_reg;
        first_next      = first_reg;
        dw_next         = dw_reg;

        if (req_take)
        begin
            word_valid_next        = 1'b1;
            word_next.data_byte    = 8'd0;
            word_next.is_read      = 1'b0;
            word_next.stop_mark    = 1'b0;
            word_next.restart_mark = 1'b0;
            word_next.status       = scws_pkg::ST_OK;
            word_next.last         = 1'b1;
            rem_next               = '0;
            first_next             = 1'b1;
            dw_next                = req.data_word;
            rd_mode_next           = req.read_not_write;

            if (req.op == scws_pkg::OP_PAYLOAD)
            begin
                // block write payload byte
                if (pay_reg == '0)
                begin
                    word_next.status = scws_pkg::ST_PAYLOAD;
                end
                else
                begin
                    word_next.data_byte = req.payload_byte;
                    word_next.stop_mark = (pay_reg == CW'(1));
                    pay_next            = pay_reg - CW'(1);
                end
            end
            else
            begin
                // header abandons any unfinished block
                pay_next = '0;
                if (req.kind == scws_pkg::KIND_BAD)
                begin
                    word_next.status = scws_pkg::ST_KIND;
                end
                else if (req.kind == scws_pkg::KIND_BLOCK && too_long)
                begin
                    word_next.status = scws_pkg::ST_LONG;
                end
                else
                begin
                    word_next.data_byte    = req.command;
                    word_next.restart_mark = 1'b1;
                    if (!req.read_not_write)
                    begin
                        case (req.kind)
                            scws_pkg::KIND_BYTE:
                            begin
                                rem_next       = CW'(1);
                                word_next.last = 1'b0;
                            end
                            scws_pkg::KIND_WORD:
                            begin
                                rem_next       = CW'(2);
                                word_next.last = 1'b0;
                            end
                            default:
                            begin
                                word_next.stop_mark = (req.block_len == 8'd0);
                                pay_next            = req.block_len[CW-1:0];
                            end
                        endcase
                    end
                    else if (rlen == '0)
                    begin
                        word_next.stop_mark = 1'b1;
                    end
                    else
                    begin
                        rem_next       = rlen;
                        word_next.last = 1'b0;
                    end
                end
            end
        end
        else if (word_take)
        begin
            // walk out the remaining words of the current request
            if (rem_reg != '0)
            begin
                word_next.data_byte    = rd_mode_reg ? 8'd0 : dw_reg[7:0];
                word_next.is_read      = rd_mode_reg;
                word_next.stop_mark    = (rem_reg == CW'(1));
                word_next.restart_mark = rd_mode_reg && first_reg;
                word_next.status       = scws_pkg::ST_OK;
                word_next.last         = (rem_reg == CW'(1));
                rem_next               = rem_reg - CW'(1);
                first_next             = 1'b0;
                dw_next                = {8'd0, dw_reg[15:8]};
            end
            else
            begin
                word_valid_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
            rem_reg        <= '0;
            pay_reg        <= '0;
        end
        else
        begin
            word_valid_reg <= word_valid_next;
            rem_reg        <= rem_next;
            pay_reg        <= pay_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        rd_mode_reg <= rd_mode_next;
        first_reg   <= first_next;
        dw_reg      <= dw_next;
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

// ----- rtl/scws_checker.sv -----
// ----------------------------------------------------------------------------
// scws_checker
// Port-level checks for the smbus command word sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module scws_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_stall,
    input wire scws_pkg::req_t  req,
    input wire logic            word_valid,
    input wire logic            word_stall,
    input wire scws_pkg::word_t word
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> word_valid && $stable(word))
    else $error("stalled command word changed");

    // error words are single and unmarked
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && (word.status != scws_pkg::ST_OK) |->
            word.last && !word.stop_mark && !word.restart_mark && !word.is_read)
    else $error("malformed error word");

    // stop only on the final word of a request
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word.stop_mark |-> word.last)
    else $error("stop mark before final word");

    // words of one request come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_stall && !word.last |=> word_valid)
    else $error("gap inside a request's words");

    // no request accepted mid-sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word.last |-> req_stall)
    else $error("request accepted before final word");

endmodule

bind smbus_command_word_sequencer scws_checker u_scws_checker (.*);

`default_nettype wire

// ----- tb/sv/smbus_command_word_sequencer_test.sv -----
// ----------------------------------------------------------------------------
// smbus_command_word_sequencer_test
// Drives transaction headers and block write payload bytes into the command
// word sequencer. Each accepted request is expanded locally into the command
// words it should produce, and every word leaving the block is compared field
// by field with the oldest pending prediction. Both channels idle at random
// except in the final back-to-back phase.
// ----------------------------------------------------------------------------
module smbus_command_word_sequencer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BlockLimit = scws_pkg::BlockMaxDefault;
    localparam int unsigned QuietLimit = 1000;
    localparam int unsigned DrainCycles = 40;
    localparam int unsigned ReqBits = $bits(scws_pkg::req_t);

    // transaction direction
    localparam logic DIR_WRITE = 1'b0;
    localparam logic DIR_READ  = 1'b1;

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    scws_pkg::req_t  req;
    logic            word_valid;
    logic            word_stall;
    scws_pkg::word_t word;

    // predictor state and bookkeeping
    scws_pkg::word_t expected_words[$];
    logic [5:0]      payload_left = '0;
    int unsigned     error_count = 0;
    int unsigned     sent_items = 0;
    int unsigned     quiet_cycles = 0;
    bit              idling_on = 1'b1;

    smbus_command_word_sequencer #(
        .BLOCK_MAX(BlockLimit)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .word_valid(word_valid),
        .word_stall(word_stall),
        .word      (word)
    );

    // clock
    always #1 clk = ~clk;

    // one line per mismatch
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic scws_pkg::word_t build_word(input logic [7:0] data, input logic rd,
                                                   input logic stop, input logic restart,
                                                   input logic [1:0] st, input logic fin);
        scws_pkg::word_t w;
        w.data_byte    = data;
        w.is_read      = rd;
        w.stop_mark    = stop;
        w.restart_mark = restart;
        w.status       = st;
        w.last         = fin;
        return w;
    endfunction

    // expand one accepted request into the command words it must produce
    task automatic predict_command_words(input scws_pkg::req_t item);
        int unsigned read_count;
        int unsigned i;
        if (item.op == scws_pkg::OP_PAYLOAD)
        begin
            if (payload_left == 0)
            begin
                expected_words.push_back(build_word(8'h00, 1'b0, 1'b0, 1'b0,
                                                    scws_pkg::ST_PAYLOAD, 1'b1));
            end
            else
            begin
                expected_words.push_back(build_word(item.payload_byte, 1'b0,
                                                    payload_left == 6'd1, 1'b0,
                                                    scws_pkg::ST_OK, 1'b1));
                payload_left = payload_left - 6'd1;
            end
        end
        else
        begin
            // any header abandons an unfinished block write
            payload_left = '0;
            if (item.kind == scws_pkg::KIND_BAD)
            begin
                expected_words.push_back(build_word(8'h00, 1'b0, 1'b0, 1'b0,
                                                    scws_pkg::ST_KIND, 1'b1));
            end
            else if (item.kind == scws_pkg::KIND_BLOCK && item.block_len > BlockLimit)
            begin
                expected_words.push_back(build_word(8'h00, 1'b0, 1'b0, 1'b0,
                                                    scws_pkg::ST_LONG, 1'b1));
            end
            else if (item.read_not_write == DIR_WRITE)
            begin
                case (item.kind)
                    scws_pkg::KIND_BYTE:
                    begin
                        expected_words.push_back(build_word(item.command, 1'b0, 1'b0, 1'b1,
                                                            scws_pkg::ST_OK, 1'b0));
                        expected_words.push_back(build_word(item.data_word[7:0], 1'b0, 1'b1,
                                                            1'b0, scws_pkg::ST_OK, 1'b1));
                    end
                    scws_pkg::KIND_WORD:
                    begin
                        expected_words.push_back(build_word(item.command, 1'b0, 1'b0, 1'b1,
                                                            scws_pkg::ST_OK, 1'b0));
                        expected_words.push_back(build_word(item.data_word[7:0], 1'b0, 1'b0,
                                                            1'b0, scws_pkg::ST_OK, 1'b0));
                        expected_words.push_back(build_word(item.data_word[15:8], 1'b0, 1'b1,
                                                            1'b0, scws_pkg::ST_OK, 1'b1));
                    end
                    default:
                    begin
                        // block write: payload bytes follow as later transfers
                        expected_words.push_back(build_word(item.command, 1'b0,
                                                            item.block_len == 8'd0, 1'b1,
                                                            scws_pkg::ST_OK, 1'b1));
                        payload_left = item.block_len[5:0];
                    end
                endcase
            end
            else
            begin
                if (item.kind == scws_pkg::KIND_BYTE)
                    read_count = 1;
                else if (item.kind == scws_pkg::KIND_WORD)
                    read_count = 2;
                else
                    read_count = 32'(item.block_len);
                if (read_count == 0)
                begin
                    expected_words.push_back(build_word(item.command, 1'b0, 1'b1, 1'b1,
                                                        scws_pkg::ST_OK, 1'b1));
                end
                else
                begin
                    expected_words.push_back(build_word(item.command, 1'b0, 1'b0, 1'b1,
                                                        scws_pkg::ST_OK, 1'b0));
                    // read requests open a second message
                    for (i = 0; i < read_count; i++)
                    begin
                        expected_words.push_back(build_word(8'h00, 1'b1, i + 1 == read_count,
                                                            i == 0, scws_pkg::ST_OK,
                                                            i + 1 == read_count));
                    end
                end
            end
        end
    endtask

    task automatic check_word(input scws_pkg::word_t got, input scws_pkg::word_t want);
        if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
        if (got.is_read !== want.is_read)
            report_mismatch("is_read", 32'(got.is_read), 32'(want.is_read));
        if (got.stop_mark !== want.stop_mark)
            report_mismatch("stop_mark", 32'(got.stop_mark), 32'(want.stop_mark));
        if (got.restart_mark !== want.restart_mark)
            report_mismatch("restart_mark", 32'(got.restart_mark), 32'(want.restart_mark));
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // predict on request transfers, check on word transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_stall === 1'b0)
                predict_command_words(req);
            if (word_valid && word_stall === 1'b0)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("word with nothing expected", 32'(word), 0);
                else
                    check_word(word, expected_words.pop_front());
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_valid && req_stall === 1'b0) || (word_valid && word_stall === 1'b0))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("smbus_command_word_sequencer_test: done, errors");
                $finish;
            end
        end
    end

    // receiver stall bursts
    always
    begin
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            word_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        word_stall <= 1'b0;
    end

    function automatic scws_pkg::req_t make_header(input logic rnw, input logic [1:0] kind,
                                                   input logic [7:0] cmd,
                                                   input logic [15:0] dw,
                                                   input logic [7:0] len);
        scws_pkg::req_t item;
        item.op             = scws_pkg::OP_HEADER;
        item.read_not_write = rnw;
        item.kind           = kind;
        item.command        = cmd;
        item.data_word      = dw;
        item.block_len      = len;
        item.payload_byte   = 8'($urandom_range(0, 255));
        return item;
    endfunction

    // payload transfer; header fields carry noise that must be ignored
    function automatic scws_pkg::req_t make_payload(input logic [7:0] data);
        scws_pkg::req_t item;
        item              = ReqBits'({$urandom, $urandom});
        item.op           = scws_pkg::OP_PAYLOAD;
        item.payload_byte = data;
        return item;
    endfunction

    // one request transfer, with an optional idle burst in front
    task automatic send_request(input scws_pkg::req_t item);
        int unsigned gap;
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 4);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic test_byte_and_word_writes();
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BYTE, 8'h00, 16'hFFFF, 8'h00));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BYTE, 8'hFF, 16'h0000, 8'hFF));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_WORD, 8'h00, 16'hFFFF, 8'hFF));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_WORD, 8'hFF, 16'h0000, 8'h00));
    endtask

    task automatic test_block_writes();
        // zero length carries both marks on the command word
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BLOCK, 8'hA5, 16'h1234, 8'd0));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BLOCK, 8'h3C, 16'h0000, 8'd2));
        send_request(make_payload(8'hFF));
        send_request(make_payload(8'h00));
        // header in the middle of a block abandons it
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BLOCK, 8'h11, 16'hFFFF, 8'd3));
        send_request(make_payload(8'h5A));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BYTE, 8'h22, 16'hABCD, 8'd3));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BLOCK, 8'h77, 16'h0000, 8'd1));
        send_request(make_payload(8'hC3));
    endtask

    task automatic test_reads();
        send_request(make_header(DIR_READ, scws_pkg::KIND_BYTE, 8'hFF, 16'hFFFF, 8'hFF));
        send_request(make_header(DIR_READ, scws_pkg::KIND_WORD, 8'h00, 16'h0000, 8'h00));
        send_request(make_header(DIR_READ, scws_pkg::KIND_BLOCK, 8'h81, 16'h0000, 8'd0));
        send_request(make_header(DIR_READ, scws_pkg::KIND_BLOCK, 8'h42, 16'h0000, 8'd1));
        send_request(make_header(DIR_READ, scws_pkg::KIND_BLOCK, 8'h99, 16'hFFFF,
                                 BlockLimit[7:0]));
    endtask

    task automatic test_errors();
        send_request(make_payload(8'hEE));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BAD, 8'h10, 16'h5555, 8'd4));
        send_request(make_header(DIR_READ, scws_pkg::KIND_BAD, 8'h20, 16'hAAAA, 8'd0));
        send_request(make_header(DIR_WRITE, scws_pkg::KIND_BLOCK, 8'h30, 16'h0000,
                                 BlockLimit[7:0] + 8'd1));
        send_request(make_header(DIR_READ, scws_pkg::KIND_BLOCK, 8'h40, 16'h0000, 8'hFF));
        // rejected block write leaves no payload pending
        send_request(make_payload(8'h01));
    endtask

    // mostly well formed transactions, some truncated blocks and stray bytes
    task automatic test_random_transactions(input int unsigned item_goal);
        int unsigned first_item;
        int unsigned pick;
        int unsigned byte_count;
        int unsigned i;
        logic        rnw;
        logic [1:0]  kind;
        logic [7:0]  len;
        first_item = sent_items;
        while (sent_items - first_item < item_goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                send_request(make_payload(8'($urandom_range(0, 255))));
            end
            else if (pick == 1)
            begin
                send_request(make_header(1'($urandom_range(0, 1)), scws_pkg::KIND_BAD,
                                         8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 65535)),
                                         8'($urandom_range(0, 255))));
            end
            else
            begin
                rnw  = 1'($urandom_range(0, 1));
                kind = 2'($urandom_range(0, 2));
                case ($urandom_range(0, 9))
                    0: len = 8'd0;
                    1: len = BlockLimit[7:0];
                    2: len = 8'($urandom_range(BlockLimit + 1, 255));
                    default: len = 8'($urandom_range(1, 6));
                endcase
                send_request(make_header(rnw, kind, 8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 65535)), len));
                if (rnw == DIR_WRITE && kind == scws_pkg::KIND_BLOCK && len <= BlockLimit)
                begin
                    byte_count = 32'(len);
                    if (len > 0 && $urandom_range(0, 7) == 0)
                        byte_count = $urandom_range(0, len - 1);
                    for (i = 0; i < byte_count; i++)
                        send_request(make_payload(8'($urandom_range(0, 255))));
                end
            end
        end
    endtask

    task automatic test_back_to_back(input int unsigned item_goal);
        idling_on = 1'b0;
        test_random_transactions(item_goal);
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        word_stall = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_byte_and_word_writes();
        test_block_writes();
        test_reads();
        test_errors();
        test_random_transactions(64);
        test_back_to_back(30);
        req_valid <= 1'b0;

        // drain outstanding words, then a short tail for stray output
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        if (expected_words.size() != 0)
            report_mismatch("words never produced", expected_words.size(), 0);
        if (error_count == 0)
            $display("smbus_command_word_sequencer_test: done, clean");
        else
            $display("smbus_command_word_sequencer_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/scws_pkg.sv
rtl/smbus_command_word_sequencer.sv
rtl/scws_checker.sv
tb/sv/smbus_command_word_sequencer_test.sv
